// File: hdl/free_extent_allocator_unit_assert.svh
// Assertion macros used by the checker file fea_checker.sv.
`ifndef FREE_EXTENT_ALLOCATOR_UNIT_ASSERT_SVH
`define FREE_EXTENT_ALLOCATOR_UNIT_ASSERT_SVH

// Condition in this cycle implies consequence in the same cycle.
`define FEA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition in this cycle implies consequence in the next cycle.
`define FEA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/fea_pkg.sv
package fea_pkg;

   localparam int MAX_EXTENTS = 16;
   localparam int ADDR_BITS   = 16;
   localparam int IDX_W       = $clog2(MAX_EXTENTS);
   localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);
   localparam int SIZE_W      = ADDR_BITS + 1;

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [SIZE_W-1:0]    size_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [1:0]           status_type;

   typedef struct packed {
      addr_type base;
      size_type size;
   } extent_type;

   localparam status_type ST_DONE   = 2'd0;
   localparam status_type ST_FULL   = 2'd1;
   localparam status_type ST_REJECT = 2'd2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam addr_type TOTAL_RESET = addr_type'(65535);

endpackage

// File: hdl/free_extent_allocator_unit.sv
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_stall  | operation, range_start, range_length
// rsp     | out       | rsp_valid/rsp_stall  | status, extent_total
// csr     | in        | csr_write_enable     | csr_write_data (total_size)
//
// One transaction at a time. A request first scans the table, reading one
// table entry per cycle through the single read port, then decides, then
// moves the entries above the change up or down for an insert or drop, and
// finally posts the result. A zero length request skips the scan.
// After reset the S_SEED state seeds the table; a csr write seeds it at once.
// A waiting result does not block the next request; rsp_stall holds only
// the finish step of the following transaction.
module free_extent_allocator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [fea_pkg::ADDR_BITS-1:0] req_range_start,
   input  logic [fea_pkg::ADDR_BITS-1:0] req_range_length,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [fea_pkg::CNT_W-1:0]     rsp_extent_total,
   input  logic                          csr_write_enable,
   input  logic [fea_pkg::ADDR_BITS-1:0] csr_write_data
);

   typedef enum logic [2:0] {
      S_SEED, S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_DONE
   } state_type;

   // extent table: one write port, one registered read port
   fea_pkg::extent_type mem [fea_pkg::MAX_EXTENTS];
   fea_pkg::extent_type rdata_ff;
   fea_pkg::idx_type    raddr;
   logic                we;
   fea_pkg::idx_type    wa;
   fea_pkg::extent_type wd;

   state_type            state_ff, state_in;
   fea_pkg::addr_type    total_ff, total_in;
   fea_pkg::cnt_type     count_ff, count_in;
   logic                 op_ff, op_in;
   fea_pkg::addr_type    start_ff, start_in;
   fea_pkg::addr_type    len_ff, len_in;
   fea_pkg::cnt_type     k_ff, k_in;
   logic                 lo_found_ff, lo_found_in;
   fea_pkg::idx_type     lo_idx_ff, lo_idx_in;
   fea_pkg::extent_type  lo_ext_ff, lo_ext_in;
   logic                 hi_found_ff, hi_found_in;
   fea_pkg::idx_type     hi_idx_ff, hi_idx_in;
   fea_pkg::extent_type  hi_ext_ff, hi_ext_in;
   fea_pkg::status_type  status_ff, status_in;
   logic                 up_ff, up_in;
   fea_pkg::cnt_type     mv_ff, mv_in;
   fea_pkg::idx_type     rj_ff, rj_in;
   logic                 pend_ff, pend_in;
   fea_pkg::idx_type     pend_wa_ff, pend_wa_in;
   fea_pkg::idx_type     ins_pos_ff, ins_pos_in;
   fea_pkg::extent_type  ins_ext_ff, ins_ext_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   fea_pkg::status_type  rsp_status_ff, rsp_status_in;
   fea_pkg::cnt_type     rsp_total_ff, rsp_total_in;

   // scan and decision helpers
   fea_pkg::cnt_type  km1;
   fea_pkg::size_type lo_end, end_v, start_x, len_x, total_x, hi_base_x;
   fea_pkg::cnt_type  pos, pcnt;
   logic              lo_cond, full, front, back, jp, jn;

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_extent_total = rsp_total_ff;

   assign km1       = k_ff - fea_pkg::cnt_type'(1);
   assign lo_end    = fea_pkg::size_type'(lo_ext_ff.base) + lo_ext_ff.size;
   assign start_x   = fea_pkg::size_type'(start_ff);
   assign len_x     = fea_pkg::size_type'(len_ff);
   assign total_x   = fea_pkg::size_type'(total_ff);
   assign hi_base_x = fea_pkg::size_type'(hi_ext_ff.base);
   assign end_v     = start_x + len_x;
   assign full      = (count_ff == fea_pkg::cnt_type'(fea_pkg::MAX_EXTENTS));
   assign front     = (start_ff == lo_ext_ff.base);
   assign back      = (end_v == lo_end);
   assign jp        = lo_found_ff && (lo_end == start_x);
   assign jn        = hi_found_ff && (hi_base_x == end_v);
   assign pos       = hi_found_ff ? fea_pkg::cnt_type'(hi_idx_ff) : count_ff;
   assign lo_cond   = (op_ff == fea_pkg::OP_ALLOC) ? (rdata_ff.base <= start_ff)
                                                   : (rdata_ff.base < start_ff);

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      start_in      = start_ff;
      len_in        = len_ff;
      k_in          = k_ff;
      lo_found_in   = lo_found_ff;
      lo_idx_in     = lo_idx_ff;
      lo_ext_in     = lo_ext_ff;
      hi_found_in   = hi_found_ff;
      hi_idx_in     = hi_idx_ff;
      hi_ext_in     = hi_ext_ff;
      status_in     = status_ff;
      up_in         = up_ff;
      mv_in         = mv_ff;
      rj_in         = rj_ff;
      pend_in       = 1'b0;
      pend_wa_in    = pend_wa_ff;
      ins_pos_in    = ins_pos_ff;
      ins_ext_in    = ins_ext_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_total_in  = rsp_total_ff;
      raddr         = k_ff[fea_pkg::IDX_W-1:0];
      we            = 1'b0;
      wa            = '0;
      wd            = '0;
      pcnt          = '0;

      case (state_ff)
         S_SEED: begin
            we       = 1'b1;
            wd.base  = '0;
            wd.size  = total_x;
            count_in = fea_pkg::cnt_type'(total_ff != '0);
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in       = req_operation;
               start_in    = req_range_start;
               len_in      = req_range_length;
               k_in        = '0;
               lo_found_in = 1'b0;
               hi_found_in = 1'b0;
               status_in   = fea_pkg::ST_DONE;
               state_in    = (req_range_length == '0) ? S_DONE : S_SCAN;
            end
         end
         S_SCAN: begin
            // entry k-1 arrives while entry k is read
            if (k_ff != '0) begin
               if (lo_cond) begin
                  lo_found_in = 1'b1;
                  lo_idx_in   = km1[fea_pkg::IDX_W-1:0];
                  lo_ext_in   = rdata_ff;
               end
               if (!(rdata_ff.base < start_ff) && !hi_found_ff) begin
                  hi_found_in = 1'b1;
                  hi_idx_in   = km1[fea_pkg::IDX_W-1:0];
                  hi_ext_in   = rdata_ff;
               end
            end
            if (k_ff == count_ff) begin
               state_in = S_DECIDE;
            end else begin
               k_in = k_ff + fea_pkg::cnt_type'(1);
            end
         end
         S_DECIDE: begin
            state_in = S_DONE;
            if (op_ff == fea_pkg::OP_ALLOC) begin
               if (!lo_found_ff || start_x >= lo_end || end_v > lo_end) begin
                  status_in = fea_pkg::ST_REJECT;
               end else if (front && back) begin
                  pcnt     = fea_pkg::cnt_type'(lo_idx_ff);
                  up_in    = 1'b0;
                  mv_in    = count_ff - fea_pkg::cnt_type'(1) - pcnt;
                  rj_in    = fea_pkg::idx_type'(pcnt + fea_pkg::cnt_type'(1));
                  count_in = count_ff - fea_pkg::cnt_type'(1);
                  state_in = S_SHIFT;
               end else if (front) begin
                  we      = 1'b1;
                  wa      = lo_idx_ff;
                  wd.base = end_v[fea_pkg::ADDR_BITS-1:0];
                  wd.size = lo_ext_ff.size - len_x;
               end else if (back) begin
                  we      = 1'b1;
                  wa      = lo_idx_ff;
                  wd.base = lo_ext_ff.base;
                  wd.size = lo_ext_ff.size - len_x;
               end else if (full) begin
                  status_in = fea_pkg::ST_FULL;
               end else begin
                  // keep the low part in place, insert the high part above it
                  we              = 1'b1;
                  wa              = lo_idx_ff;
                  wd.base         = lo_ext_ff.base;
                  wd.size         = start_x - fea_pkg::size_type'(lo_ext_ff.base);
                  pcnt            = fea_pkg::cnt_type'(lo_idx_ff) + fea_pkg::cnt_type'(1);
                  up_in           = 1'b1;
                  mv_in           = count_ff - pcnt;
                  rj_in           = fea_pkg::idx_type'(count_ff - fea_pkg::cnt_type'(1));
                  ins_pos_in      = fea_pkg::idx_type'(pcnt);
                  ins_ext_in.base = end_v[fea_pkg::ADDR_BITS-1:0];
                  ins_ext_in.size = lo_end - end_v;
                  count_in        = count_ff + fea_pkg::cnt_type'(1);
                  state_in        = S_SHIFT;
               end
            end else begin
               if (end_v > total_x || (lo_found_ff && lo_end > start_x) ||
                   (hi_found_ff && hi_base_x < end_v)) begin
                  status_in = fea_pkg::ST_REJECT;
               end else if (jp && jn) begin
                  we       = 1'b1;
                  wa       = lo_idx_ff;
                  wd.base  = lo_ext_ff.base;
                  wd.size  = lo_ext_ff.size + len_x + hi_ext_ff.size;
                  pcnt     = fea_pkg::cnt_type'(hi_idx_ff);
                  up_in    = 1'b0;
                  mv_in    = count_ff - fea_pkg::cnt_type'(1) - pcnt;
                  rj_in    = fea_pkg::idx_type'(pcnt + fea_pkg::cnt_type'(1));
                  count_in = count_ff - fea_pkg::cnt_type'(1);
                  state_in = S_SHIFT;
               end else if (jp) begin
                  we      = 1'b1;
                  wa      = lo_idx_ff;
                  wd.base = lo_ext_ff.base;
                  wd.size = lo_ext_ff.size + len_x;
               end else if (jn) begin
                  we      = 1'b1;
                  wa      = hi_idx_ff;
                  wd.base = start_ff;
                  wd.size = hi_ext_ff.size + len_x;
               end else if (full) begin
                  status_in = fea_pkg::ST_FULL;
               end else begin
                  up_in           = 1'b1;
                  mv_in           = count_ff - pos;
                  rj_in           = fea_pkg::idx_type'(count_ff - fea_pkg::cnt_type'(1));
                  ins_pos_in      = fea_pkg::idx_type'(pos);
                  ins_ext_in.base = start_ff;
                  ins_ext_in.size = len_x;
                  count_in        = count_ff + fea_pkg::cnt_type'(1);
                  state_in        = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            // move one entry per cycle: read here, write it back one place over
            raddr = rj_ff;
            if (mv_ff != '0) begin
               pend_in    = 1'b1;
               mv_in      = mv_ff - fea_pkg::cnt_type'(1);
               rj_in      = up_ff ? rj_ff - fea_pkg::idx_type'(1)
                                  : rj_ff + fea_pkg::idx_type'(1);
               pend_wa_in = up_ff ? rj_ff + fea_pkg::idx_type'(1)
                                  : rj_ff - fea_pkg::idx_type'(1);
            end
            if (pend_ff) begin
               we = 1'b1;
               wa = pend_wa_ff;
               wd = rdata_ff;
            end else if (mv_ff == '0) begin
               if (up_ff) begin
                  we = 1'b1;
                  wa = ins_pos_ff;
                  wd = ins_ext_ff;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_total_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a size write re-seeds the table; the user must send it only while idle, and the block leaves this unchecked
      if (csr_write_enable) begin
         total_in = csr_write_data;
         count_in = fea_pkg::cnt_type'(csr_write_data != '0);
         we       = 1'b1;
         wa       = '0;
         wd.base  = '0;
         wd.size  = fea_pkg::size_type'(csr_write_data);
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SEED;
         total_ff     <= fea_pkg::TOTAL_RESET;
         count_ff     <= fea_pkg::cnt_type'(1);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      start_ff      <= start_in;
      len_ff        <= len_in;
      k_ff          <= k_in;
      lo_found_ff   <= lo_found_in;
      lo_idx_ff     <= lo_idx_in;
      lo_ext_ff     <= lo_ext_in;
      hi_found_ff   <= hi_found_in;
      hi_idx_ff     <= hi_idx_in;
      hi_ext_ff     <= hi_ext_in;
      status_ff     <= status_in;
      up_ff         <= up_in;
      mv_ff         <= mv_in;
      rj_ff         <= rj_in;
      pend_wa_ff    <= pend_wa_in;
      ins_pos_ff    <= ins_pos_in;
      ins_ext_ff    <= ins_ext_in;
      rsp_status_ff <= rsp_status_in;
      rsp_total_ff  <= rsp_total_in;
   end

endmodule

// File: hdl/fea_checker.sv
`include "free_extent_allocator_unit_assert.svh"

module fea_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [1:0]                    rsp_status,
   input logic [fea_pkg::CNT_W-1:0]     rsp_extent_total
);

   `FEA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_extent_total), "stalled result changed")
   `FEA_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, rsp_status == fea_pkg::ST_DONE || rsp_status == fea_pkg::ST_FULL || rsp_status == fea_pkg::ST_REJECT, "bad status code")
   `FEA_ASSERT_NOW(a_total_range, clock, reset, rsp_valid, rsp_extent_total <= fea_pkg::CNT_W'(fea_pkg::MAX_EXTENTS), "extent total out of range")
   `FEA_ASSERT_NEXT(a_seed_stall, clock, 1'b0, reset, req_stall, "request taken while table seeds")
   `FEA_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall, "second request taken back to back")

endmodule

bind free_extent_allocator_unit fea_checker u_fea_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_extent_total (rsp_extent_total)
);
